// ----- design/rsi_pkg.sv -----
package rsi_pkg;

  localparam int MAX_WIDTH = 4096;
  localparam int MAX_SHIFT = 60;
  localparam int FRAC_BITS = 16;
  localparam int RES_LIMIT = MAX_SHIFT + 2;

  localparam int PIX_W = 24;
  localparam int LEN_W = 13;
  localparam int COL_W = 12;
  localparam int SHIFT_W = 22;
  localparam int STEP_W = 23;
  localparam int IP_W = SHIFT_W - FRAC_BITS;
  localparam int CNT_W = 6;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 24;

  localparam int SHIFT_MAX_FP = MAX_SHIFT << FRAC_BITS;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FILL_COLOR   = 3'd0,
    CFG_EXPAND_MODE  = 3'd1,
    CFG_ROW_LENGTH   = 3'd2,
    CFG_OUT_WIDTH    = 3'd3,
    CFG_START_OFFSET = 3'd4,
    CFG_ROW_STEP     = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [PIX_W-1:0]          fill_color;
    logic                      expand_mode;
    logic [LEN_W-1:0]          row_length;
    logic [LEN_W-1:0]          out_width;
    logic [SHIFT_W-1:0]        start_offset;
    logic signed [STEP_W-1:0]  row_step;
  } cfg_t;

  // One accepted source pixel together with everything needed to emit its results.
  typedef struct packed {
    logic [PIX_W-1:0]     cur;
    logic [PIX_W-1:0]     prev;
    logic [PIX_W-1:0]     fill;
    logic                 expand;
    logic [FRAC_BITS-1:0] frac;
    logic                 first;
    logic                 last;
    logic [CNT_W-1:0]     lead;
    logic [CNT_W-1:0]     cnt_last;
  } job_t;

endpackage

// ----- design/rsi_blend.sv -----
module rsi_blend
  import rsi_pkg::*;
(
  input  logic [PIX_W-1:0]     a_i,
  input  logic [PIX_W-1:0]     b_i,
  input  logic [FRAC_BITS-1:0] frac_i,
  output logic [PIX_W-1:0]     y_o
);

  localparam int ACC_W = 8 + FRAC_BITS + 2;

  logic [FRAC_BITS:0] inv;
  logic [ACC_W-1:0]   acc [3];

  assign inv = (FRAC_BITS+1)'(1 << FRAC_BITS) - {1'b0, frac_i};

  // a*f + b*(1-f) + 1/2, truncated, per channel.
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      acc[c] = ACC_W'(a_i[8*c +: 8]) * ACC_W'(frac_i)
             + ACC_W'(b_i[8*c +: 8]) * ACC_W'(inv)
             + ACC_W'(1 << (FRAC_BITS - 1));
      y_o[8*c +: 8] = acc[c][FRAC_BITS +: 8];
    end
  end

endmodule

// ----- design/rsi_job.sv -----
module rsi_job
  import rsi_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cfg_t             cfg_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [PIX_W-1:0] in_pix_i,
  input  logic             in_frame_start_i,
  input  logic             pop_i,
  output logic             job_valid_o,
  output job_t             job_o
);

  logic [SHIFT_W-1:0] shift_acc_q, shift_acc_d;
  logic [COL_W-1:0]   column_count_q, column_count_d;
  logic [PIX_W-1:0]   prev_pixel_q;
  logic               job_valid_q;
  job_t               job_q, job_d;

  logic                  accept;
  logic [LEN_W-1:0]      len;
  logic [SHIFT_W-1:0]    shift_cur;
  logic [COL_W-1:0]      col_raw, col;
  logic [IP_W-1:0]       ip;
  logic [FRAC_BITS-1:0]  frac;
  logic                  first, last, fb;
  logic [CNT_W-1:0]      lead, n_pre, room, tcnt;
  logic signed [LEN_W+1:0] trail;
  logic signed [SHIFT_W+1:0] shift_sum;

  assign accept = in_valid_i && in_ready_o;
  assign in_ready_o = !job_valid_q || pop_i;

  always_comb begin
    if (cfg_i.row_length == '0) begin
      len = LEN_W'(1);
    end else if (cfg_i.row_length > LEN_W'(MAX_WIDTH)) begin
      len = LEN_W'(MAX_WIDTH);
    end else begin
      len = cfg_i.row_length;
    end

    // A frame start reloads the shift and restarts the row.
    if (in_frame_start_i) begin
      shift_cur = (cfg_i.start_offset > SHIFT_W'(SHIFT_MAX_FP)) ?
                  SHIFT_W'(SHIFT_MAX_FP) : cfg_i.start_offset;
      col_raw = '0;
    end else begin
      shift_cur = shift_acc_q;
      col_raw = column_count_q;
    end
    col = ({1'b0, col_raw} >= len) ? '0 : col_raw;

    ip = shift_cur[SHIFT_W-1:FRAC_BITS];
    frac = shift_cur[FRAC_BITS-1:0];
    fb = |frac;
    first = (col == '0);
    last = ({1'b0, col} == len - LEN_W'(1));

    lead = first ? CNT_W'(ip) : '0;
    n_pre = lead + CNT_W'(1) + CNT_W'(last && fb);

    trail = $signed({2'b00, cfg_i.out_width}) - $signed((LEN_W+2)'(ip))
          - $signed({2'b00, len}) - $signed((LEN_W+2)'(fb));
    room = CNT_W'(RES_LIMIT) - n_pre;
    if (trail < 0) begin
      tcnt = '0;
    end else if (trail > $signed((LEN_W+2)'(room))) begin
      tcnt = room;
    end else begin
      tcnt = trail[CNT_W-1:0];
    end

    job_d.cur = in_pix_i;
    job_d.prev = prev_pixel_q;
    job_d.fill = cfg_i.fill_color;
    job_d.expand = cfg_i.expand_mode;
    job_d.frac = frac;
    job_d.first = first;
    job_d.last = last;
    job_d.lead = lead;
    job_d.cnt_last = n_pre + (last ? tcnt : '0) - CNT_W'(1);

    shift_sum = $signed({2'b00, shift_cur}) + (SHIFT_W+2)'(cfg_i.row_step);
    if (!last) begin
      shift_acc_d = shift_cur;
    end else if (shift_sum < 0) begin
      shift_acc_d = '0;
    end else if (shift_sum > $signed((SHIFT_W+2)'(SHIFT_MAX_FP))) begin
      shift_acc_d = SHIFT_W'(SHIFT_MAX_FP);
    end else begin
      shift_acc_d = shift_sum[SHIFT_W-1:0];
    end
    column_count_d = last ? '0 : col + COL_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_acc_q <= '0;
      column_count_q <= '0;
      prev_pixel_q <= '0;
      job_valid_q <= 1'b0;
    end else if (accept) begin
      shift_acc_q <= shift_acc_d;
      column_count_q <= column_count_d;
      prev_pixel_q <= in_pix_i;
      job_valid_q <= 1'b1;
    end else if (pop_i) begin
      job_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      job_q <= job_d;
    end
  end

  assign job_valid_o = job_valid_q;
  assign job_o = job_q;

endmodule

// ----- design/rsi_emit.sv -----
module rsi_emit
  import rsi_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             job_valid_i,
  input  job_t             job_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [PIX_W-1:0] out_pix_o,
  output logic             out_row_end_o,
  output logic             out_run_last_o
);

  logic [CNT_W-1:0] idx_q;
  logic             out_valid_q;
  logic [PIX_W-1:0] pix_q, pix_d;
  logic             row_end_q, run_last_q;

  logic             advance, final_res;
  logic [PIX_W-1:0] edge_pix, body_pix, tail_pix, head_blend, body_blend, tail_blend;

  assign advance = job_valid_i && (!out_valid_q || out_ready_i);
  assign final_res = (idx_q == job_i.cnt_last);
  assign pop_o = advance && final_res;

  rsi_blend u_body_blend (
    .a_i    (job_i.first ? job_i.fill : job_i.prev),
    .b_i    (job_i.cur),
    .frac_i (job_i.frac),
    .y_o    (body_blend)
  );

  rsi_blend u_tail_blend (
    .a_i    (job_i.cur),
    .b_i    (job_i.fill),
    .frac_i (job_i.frac),
    .y_o    (tail_blend)
  );

  always_comb begin
    edge_pix = job_i.expand ? job_i.cur : job_i.fill;
    head_blend = job_i.expand ? job_i.cur : body_blend;
    if (job_i.frac == '0) begin
      body_pix = job_i.cur;
    end else if (job_i.first) begin
      body_pix = head_blend;
    end else begin
      body_pix = body_blend;
    end
    tail_pix = job_i.expand ? job_i.cur : tail_blend;

    // Leading fill, body pixel, row-end blend, trailing fill; expand mode uses cur.
    if (idx_q < job_i.lead) begin
      pix_d = edge_pix;
    end else if (idx_q == job_i.lead) begin
      pix_d = body_pix;
    end else if (idx_q == job_i.lead + CNT_W'(1) && job_i.last && job_i.frac != '0) begin
      pix_d = tail_pix;
    end else begin
      pix_d = edge_pix;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        idx_q <= '0;
      end else if (advance) begin
        idx_q <= idx_q + CNT_W'(1);
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      pix_q <= pix_d;
      row_end_q <= final_res && job_i.last;
      run_last_q <= final_res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_pix_o = pix_q;
  assign out_row_end_o = row_end_q;
  assign out_run_last_o = run_last_q;

endmodule

// ----- design/row_shear_interpolator_unit.sv -----
// An accepted item is held in the job register, and its results in the output register.
// Throughput: an item yields 1 to 62 results, one per cycle from a single output register
// while the output is not stalled; the next item is accepted in the cycle its predecessor's
// last result is registered, so single-result items stream at one per cycle likewise.
// Reset clears the shift, column and previous pixel state and empties both registers;
// the settings return to fill 0, no expand, row length 1, output width 1, zero shift.
module row_shear_interpolator_unit
  import rsi_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [23:0]           s_axis_tdata,  // pix_r, pix_g, pix_b
  input  logic                  s_axis_tuser,  // frame_start
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [23:0]           m_axis_tdata,  // out_r, out_g, out_b
  output logic                  m_axis_tlast,  // row_end
  output logic                  m_axis_tuser   // run_last
);

  cfg_t             cfg_q;
  logic             pop, job_valid;
  job_t             job;
  logic [PIX_W-1:0] in_pix, out_pix;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.fill_color <= '0;
      cfg_q.expand_mode <= 1'b0;
      cfg_q.row_length <= LEN_W'(1);
      cfg_q.out_width <= LEN_W'(1);
      cfg_q.start_offset <= '0;
      cfg_q.row_step <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_FILL_COLOR:   cfg_q.fill_color <= cfg_data_i[PIX_W-1:0];
        CFG_EXPAND_MODE:  cfg_q.expand_mode <= cfg_data_i[0];
        CFG_ROW_LENGTH:   cfg_q.row_length <= cfg_data_i[LEN_W-1:0];
        CFG_OUT_WIDTH:    cfg_q.out_width <= cfg_data_i[LEN_W-1:0];
        CFG_START_OFFSET: cfg_q.start_offset <= cfg_data_i[SHIFT_W-1:0];
        CFG_ROW_STEP:     cfg_q.row_step <= cfg_data_i[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // Internal pixels keep red in the top byte.
  assign in_pix = {s_axis_tdata[7:0], s_axis_tdata[15:8], s_axis_tdata[23:16]};

  rsi_job u_job (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg_q),
    .in_valid_i       (s_axis_tvalid),
    .in_ready_o       (s_axis_tready),
    .in_pix_i         (in_pix),
    .in_frame_start_i (s_axis_tuser),
    .pop_i            (pop),
    .job_valid_o      (job_valid),
    .job_o            (job)
  );

  rsi_emit u_emit (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .job_valid_i    (job_valid),
    .job_i          (job),
    .pop_o          (pop),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .out_pix_o      (out_pix),
    .out_row_end_o  (m_axis_tlast),
    .out_run_last_o (m_axis_tuser)
  );

  assign m_axis_tdata = {out_pix[7:0], out_pix[15:8], out_pix[23:16]};

  // The end of a row always closes the results of its item.
  a_row_end_closes_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tuser)
    else $error("row end result is not the last result of its item");

  a_result_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_valid |-> job.cnt_last < CNT_W'(RES_LIMIT))
    else $error("item would produce too many results");

  a_lead_only_on_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_valid && !job.first |-> job.lead == '0)
    else $error("leading fill on a pixel that does not start a row");

  a_pop_frees_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> s_axis_tready)
    else $error("finished item does not free the input side");

endmodule
